### rtl/mgd_pkg.sv
// shared constants and widths for the midpoint grid doubler
`timescale 1ns / 1ps
`default_nettype none
package mgd_pkg;
	localparam int CELL_W       = 16;
	localparam int COORD_W      = 9;
	localparam int GRID_W       = 9;
	localparam int SHIFT_W      = 4;
	localparam int MAX_GRID_DEF = 256;
	localparam logic [31:0] SENT     = 32'hffff_ffff;
	localparam logic [15:0] MUL_OFS  = 16'h1388;
	localparam logic [13:0] DET_MASK = 14'h3fff;
	localparam logic [GRID_W-1:0]  GRID_RST  = 9'd50;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd4;
	// register indexes on the configuration port
	localparam logic REG_GRID  = 1'b0;
	localparam logic REG_SHIFT = 1'b1;
endpackage
`default_nettype wire

### rtl/mgd_if.sv
// stream interfaces for source cells and addressed result cells
`timescale 1ns / 1ps
`default_nettype none
interface mgd_in_if;
	logic                       valid;
	logic                       ready;
	logic [mgd_pkg::CELL_W-1:0] cell_height;
	logic [mgd_pkg::CELL_W-1:0] cell_detail;
	modport source (output valid, cell_height, cell_detail, input ready);
	modport sink (input valid, cell_height, cell_detail, output ready);
endinterface

interface mgd_out_if;
	logic                        valid;
	logic                        ready;
	logic [mgd_pkg::COORD_W-1:0] out_row;
	logic [mgd_pkg::COORD_W-1:0] out_col;
	logic [mgd_pkg::CELL_W-1:0]  out_height;
	logic [mgd_pkg::CELL_W-1:0]  out_detail;
	logic                        run_last;
	modport source (output valid, out_row, out_col, out_height, out_detail, run_last,
		input ready);
	modport sink (input valid, out_row, out_col, out_height, out_detail, run_last,
		output ready);
endinterface
`default_nettype wire

### rtl/midpoint_grid_doubler_top.sv
// Midpoint grid doubler: takes source cells in row-major order and emits the doubled grid
// as addressed cells. One shared midpoint unit (sum, average, roughness multiply, detail
// hash) runs eight evaluations for every cell past the first row and column, and such a
// cell gives four to sixteen results; a first-row or column-zero cell gives no result.
// Two line buffers in ram hold the previous source row and the previous center row; they
// are read before and written after the midpoint work of each cell. Writing grid_size
// restarts the frame at cell (0,0); roughness_shift is used by the midpoint unit from the write on.
`timescale 1ns / 1ps
`default_nettype none
module midpoint_grid_doubler_top #(
	parameter int MAX_GRID = mgd_pkg::MAX_GRID_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	mgd_in_if.sink           in_ch,
	mgd_out_if.source        out_ch,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire [2:0]        paddr,
	input  wire [31:0]       pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mgd_pkg::*;

	localparam int CW = $clog2(MAX_GRID);
	localparam int NW = $clog2(MAX_GRID + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDA  = 3'd1;
	localparam logic [2:0] ST_RDB  = 3'd2;
	localparam logic [2:0] ST_RDC  = 3'd3;
	localparam logic [2:0] ST_MID  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_WRA  = 3'd6;
	localparam logic [2:0] ST_WRB  = 3'd7;

	logic [2:0]         state_q;
	logic [GRID_W-1:0]  grid_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [CW-1:0]      row_q, col_q;
	logic [31:0]        cur_q, prev_q, a_q, b_q, pc_q;
	logic [31:0]        rc_q, frc_q;
	logic [31:0]        ctr_q, hz_q, vt_q, lc_q, lh_q, lv_q, vr_q, lvr_q;
	logic [1:0]         ph_q;
	logic [2:0]         op_q;
	logic [3:0]         e_q;
	logic               ov_q;

	// configuration port
	logic cfg_wr;
	logic grid_wr;
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign grid_wr = cfg_wr & (paddr[2] == REG_GRID);
	always_comb begin
		case (paddr[2])
			REG_GRID: prdata = 32'(grid_q);
			default:  prdata = 32'(shift_q);
		endcase
	end

	// effective grid size and position flags
	logic [NW-1:0] n_w;
	logic          comp, last_row, end_col, x_zero, y_zero;
	logic [3:0]    last_e;
	always_comb begin
		if (grid_q < GRID_W'(2)) begin
			n_w = NW'(2);
		end else if (int'(grid_q) > MAX_GRID) begin
			n_w = NW'(MAX_GRID);
		end else begin
			n_w = NW'(grid_q);
		end
		comp     = (row_q != '0) && (col_q != '0);
		last_row = (NW'(row_q) == n_w - NW'(1));
		end_col  = (NW'(col_q) == n_w - NW'(1));
		x_zero   = (col_q == CW'(1));
		y_zero   = (row_q == CW'(1));
		last_e   = {end_col & last_row, end_col | last_row, 2'b11};
		if (end_col && !last_row) begin
			last_e = 4'd7;
		end
	end

	// line buffers
	logic          sb_we, pcr_we;
	logic [CW-1:0] sb_waddr, sb_raddr;
	logic [31:0]   sb_wdata, sb_rdata, pcr_rdata;
	always_comb begin
		sb_we    = 1'b0;
		sb_waddr = col_q - CW'(1);
		sb_wdata = prev_q;
		sb_raddr = (state_q == ST_RDB) ? col_q : col_q - CW'(1);
		pcr_we   = (state_q == ST_WRA) && comp;
		if (state_q == ST_WRA) begin
			sb_we = (col_q != '0);
		end else if (state_q == ST_WRB) begin
			sb_we    = end_col;
			sb_waddr = col_q;
			sb_wdata = cur_q;
		end
	end

	mgd_ram #(.WIDTH(32), .DEPTH(MAX_GRID)) u_src_row (
		.clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
		.raddr(sb_raddr), .rdata(sb_rdata)
	);

	mgd_ram #(.WIDTH(32), .DEPTH(MAX_GRID)) u_ctr_row (
		.clk(clk), .we(pcr_we), .waddr(col_q - CW'(1)), .wdata(ctr_q),
		.raddr(col_q - CW'(1)), .rdata(pcr_rdata)
	);

	// operand select for the shared midpoint unit
	logic [31:0] opa, opb, opc, opd;
	always_comb begin
		case (op_q)
			3'd0: begin opa = a_q;   opb = b_q;  opc = prev_q; opd = cur_q;  end
			3'd1: begin opa = ctr_q; opb = y_zero ? SENT : pc_q; opc = a_q; opd = b_q; end
			3'd2: begin opa = rc_q;  opb = ctr_q; opc = a_q;   opd = prev_q; end
			3'd3: begin opa = prev_q; opb = cur_q; opc = SENT; opd = SENT;   end
			3'd4: begin opa = lc_q;  opb = ctr_q; opc = prev_q; opd = cur_q; end
			3'd5: begin opa = frc_q; opb = lc_q; opc = prev_q; opd = SENT;   end
			3'd6: begin opa = ctr_q; opb = SENT; opc = b_q;    opd = cur_q;  end
			default: begin opa = lc_q; opb = SENT; opc = cur_q; opd = SENT;  end
		endcase
	end

	// midpoint unit, first step: sum, average, scaled base, multiplier word
	logic [31:0]        sum;
	logic signed [15:0] avg, base;
	always_comb begin
		sum  = opa + opb + opc + opd;
		avg  = $signed(sum[31:16]) >>> 2;
		base = $signed(sum[15:0]) >>> shift_q;
	end

	logic signed [15:0] avg_s1, base_s1, mul_s1, avg_s2;
	logic [13:0]        det_s1, det_s2;
	logic signed [31:0] prod_s2;
	logic [15:0]        hgt;
	assign hgt = avg_s2 + prod_s2[31:16];

	// result select for the output register
	logic [1:0]    kind;
	logic [CW-1:0] yq, xq;
	logic [31:0]   ecell;
	always_comb begin
		case (e_q[3:2])
			2'd0:    kind = 2'd0;
			2'd1:    kind = last_row ? 2'd1 : 2'd2;
			2'd2:    kind = 2'd2;
			default: kind = 2'd3;
		endcase
		yq = kind[0] ? row_q : row_q - CW'(1);
		xq = kind[1] ? col_q : col_q - CW'(1);
		case ({kind, e_q[1:0]})
			4'd0:  ecell = a_q;
			4'd1:  ecell = hz_q;
			4'd2:  ecell = vt_q;
			4'd3:  ecell = ctr_q;
			4'd4:  ecell = prev_q;
			4'd5:  ecell = lh_q;
			4'd6:  ecell = lv_q;
			4'd7:  ecell = lc_q;
			4'd8:  ecell = b_q;
			4'd10: ecell = vr_q;
			4'd12: ecell = cur_q;
			4'd14: ecell = lvr_q;
			default: ecell = SENT;
		endcase
	end

	// output register takes a new cell when empty or being drained
	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (!ov_q || out_ch.ready);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = ov_q;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grid_q  <= GRID_RST;
			shift_q <= SHIFT_RST;
			row_q   <= '0;
			col_q   <= '0;
			prev_q  <= '0;
			rc_q    <= SENT;
			frc_q   <= SENT;
			ph_q    <= '0;
			op_q    <= '0;
			e_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			if (grid_wr) begin
				grid_q <= pwdata[GRID_W-1:0];
				row_q  <= '0;
				col_q  <= '0;
			end else if (cfg_wr) begin
				shift_q <= pwdata[SHIFT_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (!grid_wr && (NW'(row_q) >= n_w || NW'(col_q) >= n_w)) begin
							row_q <= '0;
							col_q <= '0;
						end
						state_q <= ST_RDA;
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_RDC;
				ST_RDC: begin
					ph_q    <= '0;
					op_q    <= '0;
					state_q <= comp ? ST_MID : ST_WRA;
				end
				ST_MID: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						op_q <= op_q + 3'd1;
						if (op_q == 3'd7) begin
							e_q     <= '0;
							state_q <= ST_EMIT;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						e_q <= e_q + 4'd1;
						if (e_q == last_e) begin
							state_q <= ST_WRA;
						end
					end
				end
				ST_WRA: begin
					if (comp) begin
						rc_q <= ctr_q;
						if (last_row) begin
							frc_q <= lc_q;
						end
					end
					state_q <= ST_WRB;
				end
				default: begin
					prev_q <= cur_q;
					if (!grid_wr) begin
						if (end_col) begin
							col_q <= '0;
							row_q <= last_row ? '0 : row_q + CW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			cur_q <= {in_ch.cell_height, in_ch.cell_detail};
		end
		if (state_q == ST_RDB) begin
			a_q  <= sb_rdata;
			pc_q <= pcr_rdata;
		end
		if (state_q == ST_RDC) begin
			b_q <= sb_rdata;
		end
		// midpoint pipeline steps
		avg_s1  <= avg;
		base_s1 <= base;
		mul_s1  <= {avg[12:0], 3'b000} + MUL_OFS;
		det_s1  <= (sum[13:0] ^ opa[13:0]) & DET_MASK;
		prod_s2 <= base_s1 * mul_s1;
		avg_s2  <= avg_s1;
		det_s2  <= det_s1;
		if (state_q == ST_MID && ph_q == 2'd2) begin
			case (op_q)
				3'd0: ctr_q <= {hgt, 2'b00, det_s2};
				3'd1: hz_q  <= {hgt, 2'b00, det_s2};
				3'd2: vt_q  <= x_zero ? SENT : {hgt, 2'b00, det_s2};
				3'd3: lc_q  <= {hgt, 2'b00, det_s2};
				3'd4: lh_q  <= {hgt, 2'b00, det_s2};
				3'd5: lv_q  <= x_zero ? SENT : {hgt, 2'b00, det_s2};
				3'd6: vr_q  <= {hgt, 2'b00, det_s2};
				default: lvr_q <= {hgt, 2'b00, det_s2};
			endcase
		end
		if (emit_go) begin
			out_ch.out_row    <= COORD_W'({yq, e_q[1]});
			out_ch.out_col    <= COORD_W'({xq, e_q[0]});
			out_ch.out_height <= ecell[31:16];
			out_ch.out_detail <= ecell[15:0];
			out_ch.run_last   <= (e_q == last_e);
		end
	end

`ifndef ASSERT_OFF
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while a cell is in progress");
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MID |-> NW'(col_q) < n_w && comp)
		else $error("midpoint work outside the grid");
	a_emit_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!ov_q && $past(state_q) != ST_EMIT |-> !out_ch.valid)
		else $error("result shown outside emit");
`endif
endmodule
`default_nettype wire

### rtl/mgd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### tb/tb_mgd_cells.sv
// cell predictor and result scoreboard for the midpoint grid doubler bench
`timescale 1ns / 1ps
`default_nettype none
class mgd_cell_board;
	typedef struct packed {
		logic [8:0]  row;
		logic [8:0]  col;
		logic [15:0] height;
		logic [15:0] detail;
		logic        last;
	} cell_t;

	logic [31:0] src_line [256];
	logic [31:0] ctr_line [256];
	logic [31:0] prev_cell;
	logic [31:0] run_ctr;
	logic [31:0] fin_ctr;
	int unsigned row_cnt;
	int unsigned col_cnt;
	int unsigned grid;
	int unsigned shift;
	cell_t       pending [$];
	int          errors;

	function void clear();
		foreach (src_line[i]) src_line[i] = '0;
		foreach (ctr_line[i]) ctr_line[i] = mgd_pkg::SENT;
		prev_cell = '0;
		run_ctr   = mgd_pkg::SENT;
		fin_ctr   = mgd_pkg::SENT;
		row_cnt   = 0;
		col_cnt   = 0;
		grid      = mgd_pkg::GRID_RST;
		shift     = mgd_pkg::SHIFT_RST;
		pending.delete();
		errors    = 0;
	endfunction

	function void set_reg(int idx, logic [31:0] val);
		if (idx == mgd_pkg::REG_GRID) begin
			grid    = val[8:0];
			row_cnt = 0;
			col_cnt = 0;
		end else begin
			shift = val[3:0];
		end
	endfunction

	// four-corner midpoint rule
	function logic [31:0] midpoint(logic [31:0] a, b, c, d);
		logic [31:0]        sum;
		logic signed [15:0] hi;
		logic signed [15:0] lo;
		int                 avg;
		int                 base;
		logic signed [15:0] mul;
		int                 prod;
		logic [15:0]        h;
		sum  = a + b + c + d;
		hi   = sum[31:16];
		lo   = sum[15:0];
		avg  = int'(hi) >>> 2;
		base = int'(lo) >>> shift;
		mul  = 16'(avg * 8 + 32'h1388);
		prod = base * int'(mul);
		h    = 16'(avg + (prod >>> 16));
		return {h, 2'b00, (sum[13:0] ^ a[13:0]) & mgd_pkg::DET_MASK};
	endfunction

	function void push(int unsigned r, int unsigned c, logic [31:0] v);
		cell_t e;
		e.row = 9'(r);
		e.col = 9'(c);
		e.height = v[31:16];
		e.detail = v[15:0];
		e.last = 1'b0;
		pending.push_back(e);
	endfunction

	function void push_quad(int unsigned y, x, logic [31:0] s, hz, vt, ct);
		push(2*y, 2*x, s);
		push(2*y, 2*x+1, hz);
		push(2*y+1, 2*x, vt);
		push(2*y+1, 2*x+1, ct);
	endfunction

	// note an accepted source cell and queue the cells it produces
	function void note_cell(logic [15:0] hgt, logic [15:0] det);
		int unsigned n, r, c, x, y, start_cnt;
		logic [31:0] cur, p, a, b, ct, pc, hz, vt, lc, lh, lv;
		logic        lastrow;
		n = grid < 2 ? 2 : (grid > 256 ? 256 : grid);
		cur = {hgt, det};
		r = row_cnt;
		c = col_cnt;
		p = prev_cell;
		start_cnt = pending.size();
		lc = mgd_pkg::SENT;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		if (r >= 1 && c >= 1) begin
			x = c - 1;
			y = r - 1;
			a = src_line[x];
			b = src_line[c];
			ct = midpoint(a, b, p, cur);
			pc = (y == 0) ? mgd_pkg::SENT : ctr_line[x];
			hz = midpoint(ct, pc, a, b);
			vt = (x == 0) ? mgd_pkg::SENT : midpoint(run_ctr, ct, a, p);
			lastrow = (r == n - 1);
			push_quad(y, x, a, hz, vt, ct);
			if (lastrow) begin
				lc = midpoint(p, cur, mgd_pkg::SENT, mgd_pkg::SENT);
				lh = midpoint(lc, ct, p, cur);
				lv = (x == 0) ? mgd_pkg::SENT : midpoint(fin_ctr, lc, p, mgd_pkg::SENT);
				push_quad(r, x, p, lh, lv, lc);
				fin_ctr = lc;
			end
			ctr_line[x] = ct;
			run_ctr = ct;
			if (c == n - 1) begin
				push_quad(y, c, b, mgd_pkg::SENT,
					midpoint(ct, mgd_pkg::SENT, b, cur), mgd_pkg::SENT);
				if (lastrow)
					push_quad(r, c, cur, mgd_pkg::SENT,
						midpoint(lc, mgd_pkg::SENT, cur, mgd_pkg::SENT), mgd_pkg::SENT);
			end
		end
		if (c >= 1) src_line[c-1] = p;
		if (c == n - 1) src_line[c] = cur;
		prev_cell = cur;
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n) r = 0;
		end
		row_cnt = r;
		col_cnt = c;
		if (pending.size() > start_cnt) pending[pending.size()-1].last = 1'b1;
	endfunction

	// compare one transfer with the oldest expected cell
	function void check_cell(cell_t got);
		cell_t e;
		if (pending.size() == 0) begin
			$error("unexpected cell row %0d col %0d", got.row, got.col);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.row != e.row) begin
			$error("out_row expected %0d actual %0d", e.row, got.row); errors++;
		end
		if (got.col != e.col) begin
			$error("out_col expected %0d actual %0d", e.col, got.col); errors++;
		end
		if (got.height != e.height) begin
			$error("out_height expected %h actual %h", e.height, got.height); errors++;
		end
		if (got.detail != e.detail) begin
			$error("out_detail expected %h actual %h", e.detail, got.detail); errors++;
		end
		if (got.last != e.last) begin
			$error("run_last expected %0d actual %0d", e.last, got.last); errors++;
		end
	endfunction
endclass
`default_nettype wire

### tb/tb_midpoint_grid_doubler_top.sv
// top-level bench for the midpoint grid doubler
`timescale 1ns / 1ps
`default_nettype none
module tb_midpoint_grid_doubler_top;
	import mgd_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          src_idle_pct;
	int          snk_idle_pct;
	int          hold_cycles;
	int          quiet_cycles;
	bit          timed_out;

	mgd_in_if  in_ch ();
	mgd_out_if out_ch ();
	mgd_cell_board board;

	midpoint_grid_doubler_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	initial begin
		board = new();
		board.clear();
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.cell_height = '0; in_ch.cell_detail = '0;
		out_ch.ready = 1'b0;
		src_idle_pct = 0; snk_idle_pct = 0; hold_cycles = 0;
		quiet_cycles = 0; timed_out = 1'b0;
	end

	// result side: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				board.check_cell({out_ch.out_row, out_ch.out_col, out_ch.out_height,
					out_ch.out_detail, out_ch.run_last});
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel
			|| hold_cycles > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("midpoint_grid_doubler_top test failed");
			$finish;
		end
	end

	// register write once the block is idle and every result has been taken
	task automatic write_reg(int idx, logic [31:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (!in_ch.ready || board.pending.size() != 0) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		board.set_reg(idx, val);
	endtask

	// offer one source cell, with a random gap first
	task automatic send_cell(logic [15:0] hgt, logic [15:0] det);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cell_height <= hgt;
		in_ch.cell_detail <= det;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_cell(hgt, det);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// one whole frame of random cells
	task automatic send_frame(int n);
		repeat (n * n) send_cell(pick_word(), pick_word());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest grid, extreme words, shift extremes
		src_idle_pct = 10; snk_idle_pct = 80;
		write_reg(REG_SHIFT, 0);
		write_reg(REG_GRID, 2);
		send_cell(16'h0000, 16'h0000); send_cell(16'hffff, 16'hffff);
		send_cell(16'h7fff, 16'h8000); send_cell(16'h8000, 16'h7fff);
		drain();
		write_reg(REG_SHIFT, 15);
		write_reg(REG_GRID, 3);
		send_cell(16'hffff, 16'h0000); send_cell(16'h0000, 16'hffff);
		send_cell(16'h8000, 16'h8000); send_cell(16'h7fff, 16'h7fff);
		send_cell(16'h1234, 16'habcd); send_cell(16'hfedc, 16'h5555);
		send_cell(16'haaaa, 16'h0001); send_cell(16'h0001, 16'haaaa);
		send_cell(16'hffff, 16'hffff);
		// shift change after a whole frame, then part of the next frame from the wrapped position
		write_reg(REG_SHIFT, 7);
		send_cell(16'h4000, 16'hc000); send_cell(16'hc000, 16'h4000);
		send_cell(16'h0f0f, 16'hf0f0);
		drain();
		// an out-of-range size of zero acts as the lower limit
		write_reg(REG_GRID, 0);
		send_frame(2);
		drain();

		// sender idles little, receiver much, with one long hold-off
		src_idle_pct = 10; snk_idle_pct = 80;
		write_reg(REG_SHIFT, $urandom_range(15));
		write_reg(REG_GRID, 4);
		hold_cycles = 400;
		send_frame(4);
		drain();
		src_idle_pct = 80; snk_idle_pct = 10;
		write_reg(REG_SHIFT, $urandom_range(15));
		write_reg(REG_GRID, 5);
		send_frame(5);
		drain();
		src_idle_pct = 0; snk_idle_pct = 0;
		write_reg(REG_SHIFT, 0);
		write_reg(REG_GRID, 300);
		repeat (24) send_cell(pick_word(), pick_word());
		drain();
		write_reg(REG_SHIFT, 15);
		write_reg(REG_GRID, 6);
		send_frame(6);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("midpoint_grid_doubler_top test passed");
		else
			$display("midpoint_grid_doubler_top test failed");
		$finish;
	end
endmodule
`default_nettype wire
